// File: sv/mstl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstl_pkg
// Shared types for the message seen tracker: controller states and the
// layout of one table entry as held in the entry memory.
// ----------------------------------------------------------------------------
package mstl_pkg;

    localparam int NumberW = 18;
    localparam int SourceW = 8;
    localparam int CountW  = 32;
    localparam int TimeW   = 32;
    localparam int SlotW   = 6;
    localparam int OccW    = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RD_ISSUE,
        S_RD_DATA
    } t_state;

    typedef struct packed {
        logic [NumberW-1:0] number;
        logic [SourceW-1:0] source;
        logic [CountW-1:0]  count;
        logic [TimeW-1:0]   last_ms;
    } t_entry;

endpackage

// File: sv/message_seen_tracker_lru_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_seen_tracker_lru_unit
// Fully associative table of (message number, source) pairs with
// least-recently-heard replacement, held in one single-port entry memory.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start / busy         | i_operation, i_message_number,
//            |                      | i_source_address, i_time_now_ms, i_read_slot
//  result    | o_strobe (one cycle) | o_slot_used, o_slot_valid, o_entry_*,
//            |                      | o_was_new, o_was_replaced, o_occupied
//
// A read passes through S_RD_ISSUE and S_RD_DATA. A note walks the entry
// memory one entry per cycle and stops at the first hit, or after the last
// occupied slot on a miss, then writes in S_WRITE. Reset clears only the
// occupancy and the controller. The receiver cannot stall results; busy
// holds off commands until the result is shown.
// ----------------------------------------------------------------------------
module message_seen_tracker_lru_unit #(
    parameter int ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [mstl_pkg::NumberW-1:0] i_message_number,
    input  logic [mstl_pkg::SourceW-1:0] i_source_address,
    input  logic [mstl_pkg::TimeW-1:0]   i_time_now_ms,
    input  logic [mstl_pkg::SlotW-1:0]   i_read_slot,
    output logic                        o_strobe,
    output logic [mstl_pkg::SlotW-1:0]   o_slot_used,
    output logic                        o_slot_valid,
    output logic [mstl_pkg::NumberW-1:0] o_entry_number,
    output logic [mstl_pkg::SourceW-1:0] o_entry_source,
    output logic [mstl_pkg::CountW-1:0]  o_entry_count,
    output logic [mstl_pkg::TimeW-1:0]   o_entry_last_ms,
    output logic                        o_was_new,
    output logic                        o_was_replaced,
    output logic [mstl_pkg::OccW-1:0]    o_occupied
);
    import mstl_pkg::*;

    localparam int IW   = $clog2(ENTRIES);
    localparam int FW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (FW > SlotW) ? FW : SlotW;
    localparam logic [FW-1:0] FullLevel = FW'(ENTRIES);

    // controller and datapath registers
    t_state              r_state, n_state;
    logic [FW-1:0]       r_fill, n_fill;
    logic [FW-1:0]       r_addr, n_addr;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [TimeW-1:0]    r_oldest, n_oldest;
    logic [IW-1:0]       r_pick, n_pick;
    logic [IW-1:0]       r_slot, n_slot;
    logic [CountW-1:0]   r_count, n_count;
    logic                r_new, n_new;
    logic                r_evict, n_evict;
    logic                r_rd_ok, n_rd_ok;

    // captured command
    logic [NumberW-1:0]  r_num;
    logic [SourceW-1:0]  r_src;
    logic [TimeW-1:0]    r_now;
    logic [SlotW-1:0]    r_rs;
    logic                r_op;

    // entry memory
    t_entry              mem [ENTRIES];
    t_entry              r_rdata;
    t_entry              mem_wdata;
    logic [IW-1:0]       mem_addr;
    logic                mem_re;
    logic                mem_we;

    logic                accept;
    logic                scan_issue;
    logic                hit;
    logic [TimeW-1:0]    age;

    assign accept     = start && (r_state == S_IDLE);
    assign scan_issue = (r_state == S_SCAN) && (r_addr < r_fill);
    assign hit        = r_cmp_vld && (r_rdata.number == r_num) && (r_rdata.source == r_src);
    assign age        = r_now - r_rdata.last_ms;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = i_operation ? S_RD_ISSUE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || (!r_cmp_vld && (r_addr == r_fill))) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:    n_state = S_IDLE;
            S_RD_ISSUE: n_state = S_RD_DATA;
            S_RD_DATA:  n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_oldest  = r_oldest;
        n_pick    = r_pick;
        n_slot    = r_slot;
        n_count   = r_count;
        n_new     = r_new;
        n_evict   = r_evict;
        n_rd_ok   = r_rd_ok;
        case (r_state)
            S_IDLE: begin
                // arm a fresh search and qualify the read slot
                n_addr   = '0;
                n_oldest = '0;
                n_pick   = '0;
                n_new    = 1'b0;
                n_evict  = 1'b0;
                n_rd_ok  = CMPW'(i_read_slot) < CMPW'(r_fill);
            end
            S_SCAN: begin
                // advance the walk and compare the returned entry
                if (scan_issue) begin
                    n_addr    = r_addr + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_addr[IW-1:0];
                end
                if (hit) begin
                    n_slot  = r_cmp_idx;
                    n_count = r_rdata.count + 1'b1;
                end else if (r_cmp_vld) begin
                    if (age > r_oldest) begin
                        n_oldest = age;
                        n_pick   = r_cmp_idx;
                    end
                end else if (r_addr == r_fill) begin
                    // miss: append while there is room, else evict the oldest
                    n_count = CountW'(1);
                    n_new   = 1'b1;
                    if (r_fill < FullLevel) begin
                        n_slot = r_fill[IW-1:0];
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_slot  = r_pick;
                        n_evict = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // memory port control and result strobe
    always_comb begin
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_addr[IW-1:0];
        o_strobe = 1'b0;
        case (r_state)
            S_SCAN: begin
                mem_re = scan_issue;
            end
            S_WRITE: begin
                mem_we   = 1'b1;
                mem_addr = r_slot;
                o_strobe = 1'b1;
            end
            S_RD_ISSUE: begin
                mem_re   = r_rd_ok;
                mem_addr = IW'(r_rs);
            end
            S_RD_DATA: begin
                o_strobe = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign mem_wdata = '{number: r_num, source: r_src, count: r_count, last_ms: r_now};

    // entry memory, one access per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_cmp_idx <= n_cmp_idx;
        r_oldest  <= n_oldest;
        r_pick    <= n_pick;
        r_slot    <= n_slot;
        r_count   <= n_count;
        r_new     <= n_new;
        r_evict   <= n_evict;
        r_rd_ok   <= n_rd_ok;
        if (accept) begin
            r_op  <= i_operation;
            r_num <= i_message_number;
            r_src <= i_source_address;
            r_now <= i_time_now_ms;
            r_rs  <= i_read_slot;
        end
    end

    // result fields
    always_comb begin
        o_occupied = OccW'(r_fill);
        if (r_state == S_RD_DATA) begin
            o_slot_used     = r_rs;
            o_slot_valid    = r_rd_ok;
            o_entry_number  = r_rd_ok ? r_rdata.number  : '0;
            o_entry_source  = r_rd_ok ? r_rdata.source  : '0;
            o_entry_count   = r_rd_ok ? r_rdata.count   : '0;
            o_entry_last_ms = r_rd_ok ? r_rdata.last_ms : '0;
            o_was_new       = 1'b0;
            o_was_replaced  = 1'b0;
        end else begin
            o_slot_used     = SlotW'(r_slot);
            o_slot_valid    = 1'b1;
            o_entry_number  = r_num;
            o_entry_source  = r_src;
            o_entry_count   = r_count;
            o_entry_last_ms = r_now;
            o_was_new       = r_new;
            o_was_replaced  = r_evict;
        end
    end

    assign busy = (r_state != S_IDLE);

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FullLevel)
        else $error("occupancy beyond table size");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_replaced) |-> (r_fill == FullLevel && o_was_new))
        else $error("eviction while table not full");

    a_strobe_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy && ((r_state == S_RD_DATA) == r_op)))
        else $error("result kind does not match the transaction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accepting a transaction");

    a_append_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_new && !o_was_replaced) |->
            (r_fill != '0 && r_slot == IW'(r_fill - 1'b1)))
        else $error("appended entry not at the top of the table");

endmodule

// File: sim/mstl_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstl_test_pkg
// Operation codes and the result layout shared by the tracker test bench and
// its result checker.
// ----------------------------------------------------------------------------
package mstl_test_pkg;

    import mstl_pkg::*;

    // Slot count of the block as instantiated in the bench
    localparam int TableSlots = 64;

    typedef enum logic {
        OP_NOTE = 1'b0,
        OP_READ = 1'b1
    } t_tracker_op;

    // One result transaction, field for field as on the result ports
    typedef struct packed {
        logic [SlotW-1:0]   slot_used;
        logic               slot_valid;
        logic [NumberW-1:0] entry_number;
        logic [SourceW-1:0] entry_source;
        logic [CountW-1:0]  entry_count;
        logic [TimeW-1:0]   entry_last_ms;
        logic               was_new;
        logic               was_replaced;
        logic [OccW-1:0]    occupied;
    } t_tracker_result;

endpackage

// File: sim/mstl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstl_result_checker
// Watches the command and result channels of the tracker, keeps its own copy
// of the seen-message table to predict each result, and compares every result
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module mstl_result_checker
    import mstl_pkg::*;
    import mstl_test_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_operation,
    input  logic [NumberW-1:0] i_message_number,
    input  logic [SourceW-1:0] i_source_address,
    input  logic [TimeW-1:0]   i_time_now_ms,
    input  logic [SlotW-1:0]   i_read_slot,
    input  logic               i_strobe,
    input  logic [SlotW-1:0]   i_slot_used,
    input  logic               i_slot_valid,
    input  logic [NumberW-1:0] i_entry_number,
    input  logic [SourceW-1:0] i_entry_source,
    input  logic [CountW-1:0]  i_entry_count,
    input  logic [TimeW-1:0]   i_entry_last_ms,
    input  logic               i_was_new,
    input  logic               i_was_replaced,
    input  logic [OccW-1:0]    i_occupied,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int ReportLimit = 10;

    // Shadow copy of the table
    logic [NumberW-1:0] tag_number [TableSlots];
    logic [SourceW-1:0] tag_source [TableSlots];
    logic [CountW-1:0]  hit_count  [TableSlots];
    logic [TimeW-1:0]   last_heard [TableSlots];
    logic [OccW-1:0]    fill_level;

    t_tracker_result predicted_results_q[$];
    t_tracker_result seen_result;
    t_tracker_result wanted_result;
    int              fail_total = 0;

    // Apply one command to the shadow table and return the result it gives
    function automatic t_tracker_result track_heard_message(
        input t_tracker_op        op,
        input logic [NumberW-1:0] number,
        input logic [SourceW-1:0] source,
        input logic [TimeW-1:0]   now_ms,
        input logic [SlotW-1:0]   slot
    );
        t_tracker_result  res;
        int               hit;
        logic [TimeW-1:0] oldest;
        logic [TimeW-1:0] age;
        res = '0;
        if (op == OP_READ) begin
            res.slot_used = slot;
            if (slot < fill_level) begin
                res.slot_valid    = 1'b1;
                res.entry_number  = tag_number[slot];
                res.entry_source  = tag_source[slot];
                res.entry_count   = hit_count[slot];
                res.entry_last_ms = last_heard[slot];
            end
            res.occupied = fill_level;
            return res;
        end
        // search occupied slots, first match wins
        hit = -1;
        for (int k = 0; k < TableSlots; k++) begin
            if (hit < 0 && k < fill_level && tag_number[k] == number &&
                tag_source[k] == source)
                hit = k;
        end
        if (hit < 0) begin
            res.was_new = 1'b1;
            if (fill_level < TableSlots) begin
                hit        = fill_level;
                fill_level = fill_level + 1'b1;
            end else begin
                // evict the largest wrapped age, lowest slot on ties
                oldest = '0;
                hit    = 0;
                for (int k = 0; k < TableSlots; k++) begin
                    age = now_ms - last_heard[k];
                    if (age > oldest) begin
                        oldest = age;
                        hit    = k;
                    end
                end
                res.was_replaced = 1'b1;
            end
            tag_number[hit] = number;
            tag_source[hit] = source;
            hit_count[hit]  = '0;
        end
        hit_count[hit]  = hit_count[hit] + 1'b1;
        last_heard[hit] = now_ms;
        res.slot_used     = hit[SlotW-1:0];
        res.slot_valid    = 1'b1;
        res.entry_number  = tag_number[hit];
        res.entry_source  = tag_source[hit];
        res.entry_count   = hit_count[hit];
        res.entry_last_ms = last_heard[hit];
        res.occupied      = fill_level;
        return res;
    endfunction

    // Compare results first, then queue the prediction for a new command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level = '0;
            predicted_results_q.delete();
        end else begin
            if (i_strobe) begin
                seen_result = '{i_slot_used, i_slot_valid, i_entry_number,
                                i_entry_source, i_entry_count, i_entry_last_ms,
                                i_was_new, i_was_replaced, i_occupied};
                if (predicted_results_q.size() == 0) begin
                    if (fail_total < ReportLimit)
                        $display("%0t: result with nothing expected: slot %0d", $realtime,
                                 seen_result.slot_used);
                    fail_total++;
                end else begin
                    wanted_result = predicted_results_q.pop_front();
                    if (seen_result !== wanted_result) begin
                        if (fail_total < ReportLimit) begin
                            $display("%0t: mismatch expected slot %0d vld %b num %h src %h",
                                     $realtime, wanted_result.slot_used,
                                     wanted_result.slot_valid, wanted_result.entry_number,
                                     wanted_result.entry_source);
                            $display("    cnt %h last %h new %b repl %b occ %0d",
                                     wanted_result.entry_count, wanted_result.entry_last_ms,
                                     wanted_result.was_new, wanted_result.was_replaced,
                                     wanted_result.occupied);
                            $display("  actual slot %0d vld %b num %h src %h",
                                     seen_result.slot_used, seen_result.slot_valid,
                                     seen_result.entry_number, seen_result.entry_source);
                            $display("    cnt %h last %h new %b repl %b occ %0d",
                                     seen_result.entry_count, seen_result.entry_last_ms,
                                     seen_result.was_new, seen_result.was_replaced,
                                     seen_result.occupied);
                        end
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy)
                predicted_results_q.push_back(track_heard_message(
                    t_tracker_op'(i_operation), i_message_number, i_source_address,
                    i_time_now_ms, i_read_slot));
        end
        o_fail_count <= fail_total;
        o_pending    <= predicted_results_q.size();
    end

endmodule

// File: sim/message_seen_tracker_lru_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_seen_tracker_lru_unit_test
// Drives note and read commands into the seen-message tracker: a directed
// opening, a full-table fill with equal timestamps, then random traffic over a
// pool of pairs larger than the table so that hits, appends and evictions mix.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module message_seen_tracker_lru_unit_test;

    import mstl_pkg::*;
    import mstl_test_pkg::*;

    localparam int PoolPairs   = 96;
    localparam int PhaseItems  = 480;
    localparam int TailCycles  = 80;
    localparam int StallLimit  = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [NumberW-1:0] i_message_number;
    logic [SourceW-1:0] i_source_address;
    logic [TimeW-1:0]   i_time_now_ms;
    logic [SlotW-1:0]   i_read_slot;
    logic               o_strobe;
    logic [SlotW-1:0]   o_slot_used;
    logic               o_slot_valid;
    logic [NumberW-1:0] o_entry_number;
    logic [SourceW-1:0] o_entry_source;
    logic [CountW-1:0]  o_entry_count;
    logic [TimeW-1:0]   o_entry_last_ms;
    logic               o_was_new;
    logic               o_was_replaced;
    logic [OccW-1:0]    o_occupied;

    int                 fail_count;
    int                 pending_count;
    int                 stall_cycles = 0;
    int                 sender_idle_pct = 27;
    logic [NumberW-1:0] pool_number [PoolPairs];
    logic [SourceW-1:0] pool_source [PoolPairs];

    message_seen_tracker_lru_unit #(
        .ENTRIES(TableSlots)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_message_number(i_message_number),
        .i_source_address(i_source_address),
        .i_time_now_ms   (i_time_now_ms),
        .i_read_slot     (i_read_slot),
        .o_strobe        (o_strobe),
        .o_slot_used     (o_slot_used),
        .o_slot_valid    (o_slot_valid),
        .o_entry_number  (o_entry_number),
        .o_entry_source  (o_entry_source),
        .o_entry_count   (o_entry_count),
        .o_entry_last_ms (o_entry_last_ms),
        .o_was_new       (o_was_new),
        .o_was_replaced  (o_was_replaced),
        .o_occupied      (o_occupied)
    );

    mstl_result_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_message_number(i_message_number),
        .i_source_address(i_source_address),
        .i_time_now_ms   (i_time_now_ms),
        .i_read_slot     (i_read_slot),
        .i_strobe        (o_strobe),
        .i_slot_used     (o_slot_used),
        .i_slot_valid    (o_slot_valid),
        .i_entry_number  (o_entry_number),
        .i_entry_source  (o_entry_source),
        .i_entry_count   (o_entry_count),
        .i_entry_last_ms (o_entry_last_ms),
        .i_was_new       (o_was_new),
        .i_was_replaced  (o_was_replaced),
        .i_occupied      (o_occupied),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Count cycles in which no transaction moves on either channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Drive one command at the falling edge and hold it until accepted
    task automatic send_command(
        input t_tracker_op        op,
        input logic [NumberW-1:0] number,
        input logic [SourceW-1:0] source,
        input logic [TimeW-1:0]   now_ms,
        input logic [SlotW-1:0]   slot
    );
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start            = 1'b1;
        i_operation      = op;
        i_message_number = number;
        i_source_address = source;
        i_time_now_ms    = now_ms;
        i_read_slot      = slot;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic note_pair(
        input logic [NumberW-1:0] number,
        input logic [SourceW-1:0] source,
        input logic [TimeW-1:0]   now_ms
    );
        send_command(OP_NOTE, number, source, now_ms, SlotW'($urandom));
    endtask

    task automatic read_table_slot(input logic [SlotW-1:0] slot);
        send_command(OP_READ, NumberW'($urandom), SourceW'($urandom), $urandom, slot);
    endtask

    initial begin
        logic [TimeW-1:0] fill_time;
        logic [TimeW-1:0] now_ms;
        int               roll;
        int               pick;

        start            = 1'b0;
        i_operation      = OP_NOTE;
        i_message_number = '0;
        i_source_address = '0;
        i_time_now_ms    = '0;
        i_read_slot      = '0;
        i_rst_n          = 1'b0;

        // distinct pairs: the source carries the pool index, never 0 or all ones
        for (int p = 0; p < PoolPairs; p++) begin
            pool_number[p] = NumberW'($urandom);
            pool_source[p] = SourceW'(p + 16);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed opening: empty reads, field extremes, hits, near-miss pairs
        read_table_slot('0);
        read_table_slot('1);
        note_pair('0, '0, '0);
        note_pair('1, '1, '1);
        note_pair('0, '0, 32'd5);
        note_pair('0, '1, 32'd5);
        note_pair('1, '0, '1);
        note_pair('1, '1, 32'd2);
        read_table_slot(6'd0);
        read_table_slot(6'd1);
        read_table_slot(6'd3);
        read_table_slot(6'd4);
        read_table_slot('1);

        // fill the table at one timestamp, then miss with every age zero
        fill_time = $urandom;
        for (int p = 0; p < TableSlots; p++)
            note_pair(pool_number[p], pool_source[p], fill_time);
        note_pair(pool_number[TableSlots], pool_source[TableSlots], fill_time);
        read_table_slot(6'd0);

        // random traffic: mostly pool pairs with slowly moving time
        now_ms = fill_time;
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 82 : 0;
            for (int n = 0; n < PhaseItems; n++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 19) == 0)
                    now_ms = $urandom;
                else
                    now_ms = now_ms + $urandom_range(0, 3);
                if (roll < 25) begin
                    read_table_slot(SlotW'($urandom));
                end else if (roll < 85) begin
                    pick = $urandom_range(0, PoolPairs - 1);
                    note_pair(pool_number[pick], pool_source[pick], now_ms);
                end else begin
                    note_pair(NumberW'($urandom), SourceW'($urandom), now_ms);
                end
            end
        end

        // drain outstanding results
        @(negedge i_clk);
        start = 1'b0;
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("message_seen_tracker_lru_unit_test: done, clean");
        else
            $display("message_seen_tracker_lru_unit_test: done, errors");
        $finish;
    end

    // Watchdog: end the run when traffic stops moving
    initial begin
        while (stall_cycles < StallLimit)
            @(posedge i_clk);
        $display("message_seen_tracker_lru_unit_test: done, errors");
        $finish;
    end

endmodule
